// ===== hdl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg: shared codes and types for the sorted multiset engine
// opcodes, result kinds and the packed result record
// ----------------------------------------------------------------------------
`default_nettype none
package sme_pkg;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_ERASE_ONE = 3'd1,
    OP_ERASE_ALL = 3'd2,
    OP_FIND      = 3'd3,
    OP_COUNT     = 3'd4,
    OP_PRINT     = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_NONE      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    K_ELEM  = 3'd0,
    K_EMPTY = 3'd1,
    K_FIND  = 3'd2,
    K_COUNT = 3'd3,
    K_OVER  = 3'd4
  } kind_t;

  localparam int unsigned ELEM_W  = 64;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    kind_t               kind;
    logic [ELEM_W-1:0]   value;
    logic                found;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/sme_ram.sv =====
// ----------------------------------------------------------------------------
// sme_ram: generic single-port synchronous RAM
// one access a cycle: an optional write plus a read of the old word, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module sme_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== hdl/sme_ctrl.sv =====
// ----------------------------------------------------------------------------
// sme_ctrl: sequencer for the sorted multiset engine
// scans the store, shifts entries for insert and erase, streams print output
// ----------------------------------------------------------------------------
`default_nettype none
module sme_ctrl #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire logic [2:0]               req_op,
  input  wire logic [VALUE_BITS-1:0]    req_val,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output sme_pkg::result_t              res,
  output logic                          mem_we,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_addr,
  output logic [VALUE_BITS-1:0]         mem_wdata,
  input  wire logic [VALUE_BITS-1:0]    mem_rdata
);
  import sme_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned TW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DISPATCH, S_SHIFT_RD, S_SHIFT_WR,
    S_INS_WR, S_PRINT_RD, S_PRINT_OUT, S_OUT
  } state_t;

  state_t              state_r;
  op_t                 op_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [TW-1:0]       total_r;
  logic [TW-1:0]       idx_r;   // scan / shift / print index
  logic [TW-1:0]       lo_r;    // first not below
  logic [TW-1:0]       hi_r;    // first above
  logic                lo_done_r;
  logic [TW-1:0]       gap_r;
  result_t             res_r;
  logic                res_valid_r;

  // signed compare of a stored entry against the operand
  logic rd_lt, rd_gt;
  assign rd_lt = $signed(mem_rdata) < $signed(val_r);
  assign rd_gt = $signed(mem_rdata) > $signed(val_r);

  assign req_ready = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_r[AW-1:0];
    mem_wdata = mem_rdata;
    unique case (state_r)
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        if (op_r == OP_ADD) begin
          mem_addr = idx_r[AW-1:0];
        end else begin
          mem_addr = AW'(idx_r - gap_r);
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_addr  = hi_r[AW-1:0];
        mem_wdata = val_r;
      end
      S_SHIFT_RD: begin
        if (op_r == OP_ADD) begin
          mem_addr = AW'(idx_r - TW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            op_r      <= op_t'(req_op);
            val_r     <= req_val;
            idx_r     <= '0;
            lo_r      <= total_r;
            hi_r      <= total_r;
            lo_done_r <= 1'b0;
            unique case (op_t'(req_op))
              OP_CLEAR: total_r <= '0;
              OP_NONE:  ;
              OP_ADD: begin
                if (total_r == TW'(CAPACITY)) begin
                  res_r   <= result_t'{kind: K_OVER, value: '0, found: 1'b0,
                                       count: '0, last: 1'b1};
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_SCAN_RD;
                end
              end
              OP_PRINT: begin
                if (total_r == '0) begin
                  res_r   <= result_t'{kind: K_EMPTY, value: '0, found: 1'b0,
                                       count: '0, last: 1'b1};
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_PRINT_RD;
                end
              end
              default: state_r <= S_SCAN_RD;
            endcase
          end
        end
        S_SCAN_RD: begin
          // linear scan through the read port: each entry is read, then checked
          if (idx_r == total_r) begin
            state_r <= S_DISPATCH;
          end else begin
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (!lo_done_r && !rd_lt) begin
            lo_r      <= idx_r;
            lo_done_r <= 1'b1;
          end
          if (rd_gt) begin
            hi_r    <= idx_r;
            state_r <= S_DISPATCH;
          end else begin
            idx_r   <= idx_r + TW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_DISPATCH: begin
          priority case (op_r)
            OP_FIND: begin
              res_r   <= result_t'{kind: K_FIND, value: '0, found: (hi_r != lo_r),
                                   count: '0, last: 1'b1};
              state_r <= S_OUT;
            end
            OP_COUNT: begin
              res_r   <= result_t'{kind: K_COUNT, value: '0, found: 1'b0,
                                   count: COUNT_W'(hi_r - lo_r), last: 1'b1};
              state_r <= S_OUT;
            end
            OP_ADD: begin
              idx_r   <= total_r;
              state_r <= (total_r == hi_r) ? S_INS_WR : S_SHIFT_RD;
            end
            default: begin
              // erase one or all: gap width, then move tail down
              gap_r   <= (op_r == OP_ERASE_ONE && hi_r != lo_r) ? TW'(1) :
                         TW'(hi_r - lo_r);
              idx_r   <= (op_r == OP_ERASE_ONE && hi_r != lo_r) ?
                         TW'(lo_r + TW'(1)) : hi_r;
              state_r <= (hi_r == lo_r) ? S_IDLE : S_SHIFT_RD;
            end
          endcase
        end
        S_SHIFT_RD: begin
          if (op_r != OP_ADD && idx_r == total_r) begin
            total_r <= TW'(total_r - gap_r);
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          if (op_r == OP_ADD) begin
            idx_r   <= idx_r - TW'(1);
            state_r <= (TW'(idx_r - TW'(1)) == hi_r) ? S_INS_WR : S_SHIFT_RD;
          end else begin
            idx_r   <= idx_r + TW'(1);
            state_r <= S_SHIFT_RD;
          end
        end
        S_INS_WR: begin
          total_r <= total_r + TW'(1);
          state_r <= S_IDLE;
        end
        S_PRINT_RD: begin
          if (!res_valid_r || res_ready) begin
            state_r <= S_PRINT_OUT;
          end
        end
        S_PRINT_OUT: begin
          res_r       <= result_t'{kind: K_ELEM, value: ELEM_W'($signed(mem_rdata)),
                                   found: 1'b0, count: '0,
                                   last: (idx_r + TW'(1) == total_r)};
          res_valid_r <= 1'b1;
          idx_r       <= idx_r + TW'(1);
          state_r     <= (idx_r + TW'(1) == total_r) ? S_IDLE : S_PRINT_RD;
        end
        S_OUT: begin
          res_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sorted_multiset_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_multiset_engine_unit: bounded sorted multiset of signed values
// add, erase, find, count, print and clear over one single-port store
// ----------------------------------------------------------------------------
//  channel | direction | tdata                        | tuser | tlast
//  in_     | slave     | operand_value                | opcode| -
//  out_    | master    | element_value,found,count    | kind  | last_of_run
//
// find, count, erase and add scan the store one entry at a time, a read state
// and then a check state for each entry; an add or erase then moves entries
// through a read state and a write state each, and an add writes the new value
// print streams the elements in order through a read and an output state each
// and waits while the sink stalls; the single RAM port sets this pace; total count resets to zero
// a stalled result holds the sequencer; input is taken only when idle
`default_nettype none
module sorted_multiset_engine_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // operand_value[63:0]
  input  wire logic [2:0]   in_tuser,   // opcode[2:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [71:0]       out_tdata,  // element_value[63:0], was_found[64], copy_count[71:65]
  output logic [2:0]        out_tuser,  // result_kind[2:0]
  output logic              out_tlast   // last_of_run
);
  import sme_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  result_t                res;
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [VALUE_BITS-1:0]  mem_wdata, mem_rdata;

  sme_ctrl #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_tuser),
    .req_val   (in_tdata[VALUE_BITS-1:0]),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  sme_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign out_tdata = {res.count, res.found, res.value};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;
endmodule
`default_nettype wire

// ===== hdl/sme_checker.sv =====
// ----------------------------------------------------------------------------
// sme_checker: port-level checks for the sorted multiset engine
// result shape rules, no input during output and output hold under stall
// ----------------------------------------------------------------------------
`default_nettype none
module sme_port_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);
  import sme_pkg::*;

  // output valid and data hold while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // only printed elements may be non-final
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != K_ELEM |-> out_tlast)
    else $error("single result without last");

  // no new request while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken during output");

  // non-element kinds carry a zero value
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != K_ELEM |-> out_tdata[63:0] == 64'd0)
    else $error("nonzero value on answer");
endmodule

bind sorted_multiset_engine_unit sme_port_props u_sme_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire
